// ----- design/deqs_pkg.sv -----
// ---------------------------------------------------------------------------
// deqs_pkg: shared types and codes for the double-ended queue with search
// Request, response and internal command formats plus operation codes.
// ---------------------------------------------------------------------------
package deqs_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// request function codes
	localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [2:0] FUNC_DROP_FRONT = 3'd2;
	localparam logic [2:0] FUNC_DROP_BACK  = 3'd3;
	localparam logic [2:0] FUNC_SEARCH     = 3'd4;

	// response status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [4:0] count;
		logic [1:0] status;
	} rsp_t;

	// decoded command; all flags low means no operation
	typedef struct packed {
		logic        push;
		logic        drop;
		logic        search;
		logic        front_end;
		logic [31:0] value;
	} cmd_t;

endpackage

// ----- design/deqs_front.sv -----
// ---------------------------------------------------------------------------
// deqs_front: request intake
// Accepts request beats, decodes the function code and buffers the decoded
// commands in a two-entry queue toward the execution side.
// ---------------------------------------------------------------------------
module deqs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  deqs_pkg::req_t  req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output deqs_pkg::cmd_t  cmd
);
	import deqs_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       wr_en;
	logic       rd_en;
	cmd_t       dec;

	function automatic cmd_t classify(req_t r);
		cmd_t c;
		c = '0;
		c.value = r.value;
		case (r.func)
			FUNC_PUSH_FRONT: begin
				c.push      = 1'b1;
				c.front_end = 1'b1;
			end
			FUNC_PUSH_BACK: begin
				c.push = 1'b1;
			end
			FUNC_DROP_FRONT: begin
				c.drop      = 1'b1;
				c.front_end = 1'b1;
			end
			FUNC_DROP_BACK: begin
				c.drop = 1'b1;
			end
			FUNC_SEARCH: begin
				c.search = 1'b1;
			end
			default: begin
				c.push = 1'b0;
			end
		endcase
		return c;
	endfunction

	assign dec       = classify(req);
	assign req_ready = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign wr_en     = req_valid && req_ready;
	assign rd_en     = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en) fill_q <= fill_q + 2'd1;
			else if (!wr_en && rd_en) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= dec;
	end

endmodule

// ----- design/deqs_back.sv -----
// ---------------------------------------------------------------------------
// deqs_back: command execution
// Holds the circular store, front position and occupancy, runs pushes and
// drops, walks the stored entries for a search, registers the response beat.
// ---------------------------------------------------------------------------
module deqs_back #(
	parameter int DEPTH      = deqs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deqs_pkg::DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  deqs_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output deqs_pkg::rsp_t  rsp
);
	import deqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SRCH = 1'b1;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [AW-1:0]         front_q;
	logic [CW-1:0]         occ_q;
	logic                  state_q;
	logic [AW-1:0]         idx_q;
	logic                  issue_q;
	logic                  valid_s1;
	logic                  last_s1;
	logic [DATA_WIDTH-1:0] rdata_s1;
	logic [DATA_WIDTH-1:0] key_q;
	logic                  res_valid_q;
	rsp_t                  res_q;

	logic                  out_free;
	logic                  take;
	logic                  full;
	logic                  empty;
	logic                  srch_start;
	logic [63:0]           value64;
	logic [DATA_WIDTH-1:0] word;
	logic [AW-1:0]         front_nx;
	logic [CW-1:0]         occ_nx;
	logic [1:0]            status;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic                  last_issue;
	logic                  hit;
	logic                  finish;
	logic                  res_load;
	rsp_t                  res_d;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [4:0] count5(logic [CW-1:0] o);
		logic [15:0] w;
		w = 16'(o);
		return w[4:0];
	endfunction

	assign out_free   = !res_valid_q || rsp_ready;
	assign cmd_ready  = (state_q == ST_IDLE) && out_free;
	assign take       = cmd_valid && cmd_ready;
	assign full       = (occ_q == CW'(DEPTH));
	assign empty      = (occ_q == '0);
	assign srch_start = take && cmd.search && !empty;
	assign value64    = {32'b0, cmd.value};
	assign word       = value64[DATA_WIDTH-1:0];

	always_comb begin
		front_nx = front_q;
		occ_nx   = occ_q;
		status   = STATUS_DONE;
		we       = 1'b0;
		waddr    = wrap_add(front_q, AW'(occ_q));
		if (cmd.push) begin
			if (full) begin
				status = STATUS_FULL;
			end else begin
				we     = take;
				occ_nx = occ_q + CW'(1);
				if (cmd.front_end) begin
					front_nx = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
					waddr    = front_nx;
				end
			end
		end else if (cmd.drop) begin
			if (empty) begin
				status = STATUS_EMPTY;
			end else begin
				occ_nx = occ_q - CW'(1);
				if (cmd.front_end) front_nx = wrap_add(front_q, AW'(1));
			end
		end
	end

	// search walk: one read issued per cycle, compared against the key in the next cycle
	assign raddr      = wrap_add(front_q, idx_q);
	assign last_issue = ((CW'(idx_q) + CW'(1)) == occ_q);
	assign hit        = valid_s1 && (rdata_s1 == key_q);
	assign finish     = valid_s1 && (hit || last_s1);
	assign res_load   = (take && !srch_start) || finish;

	always_comb begin
		if (finish) begin
			res_d.found  = hit;
			res_d.count  = count5(occ_q);
			res_d.status = STATUS_DONE;
		end else begin
			res_d.found  = 1'b0;
			res_d.count  = count5(occ_nx);
			res_d.status = status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			occ_q       <= '0;
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				front_q <= front_nx;
				occ_q   <= occ_nx;
			end
			if (srch_start) begin
				state_q <= ST_SRCH;
				idx_q   <= '0;
				issue_q <= 1'b1;
			end else if (state_q == ST_SRCH) begin
				if (finish) begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
				end else if (issue_q) begin
					if (last_issue) issue_q <= 1'b0;
					else idx_q <= idx_q + AW'(1);
				end
			end
			valid_s1 <= (state_q == ST_SRCH) && issue_q && !finish;
			if (res_load) res_valid_q <= 1'b1;
			else if (rsp_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= word;
		rdata_s1 <= mem[raddr];
		last_s1  <= last_issue;
		if (take) key_q <= word;
		if (res_load) res_q <= res_d;
	end

	assign rsp_valid = res_valid_q;
	assign rsp       = res_q;

	a_srch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> occ_q != '0)
		else $error("search walk running on an empty store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("response register loaded while a beat is held");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == STATUS_FULL |-> full)
		else $error("full status reported while store has room");

	a_cmp_in_srch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_SRCH)
		else $error("compare stage active outside a search");

endmodule

// ----- design/double_ended_queue_with_search.sv -----
// ---------------------------------------------------------------------------
// double_ended_queue_with_search: bounded deque with membership search
// Circular store of DEPTH words with push/drop at either end and a search.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one request beat: func and
//   value. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one beat per
//   request, in order: found, count after the step, status.
//   Intake decodes each beat into a two-entry command queue, so the request
//   side keeps moving while execution or the response side stalls.
//   Push, drop and unused codes pass through the command queue and the
//   response register. A search holds execution while the walk reads one
//   entry a cycle from the store's one registered read port, stopping at
//   the first hit or after the last stored entry. Throughput: one
//   push/drop per cycle unless the response side stalls; a search holds
//   execution for its walk while intake still buffers up to two more requests.
//   Reset (arst_n low) empties the store: occupancy and front position go
//   to zero; the words themselves are never cleared and are read only once
//   written. No clearing pass is needed.
//   When rsp_ready is low the response beat holds, execution stops taking
//   commands, and req_ready drops once the command queue is full.
// ---------------------------------------------------------------------------
module double_ended_queue_with_search #(
	parameter int DEPTH      = deqs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deqs_pkg::DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  deqs_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output deqs_pkg::rsp_t  rsp
);
	import deqs_pkg::*;

	// decoded command beat between intake and execution
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// intake: decode and buffer
	deqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// execution: store, search walk and response register
	deqs_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
